// File: rtl/sts_pkg.sv
// shared types, command codes and scratchpad helpers for the scratchpad handler
package sts_pkg;

  // command bytes
  localparam logic [7:0] CMD_WRITE   = 8'h4E;
  localparam logic [7:0] CMD_READ    = 8'hBE;
  localparam logic [7:0] CMD_RECALL  = 8'hB8;
  localparam logic [7:0] CMD_POWER   = 8'hB4;
  localparam logic [7:0] CMD_CONVERT = 8'h44;

  // fixed scratchpad content
  localparam logic [7:0] PAD_TEMP_LSB = 8'hA0;
  localparam logic [7:0] PAD_TEMP_MSB = 8'h00;
  localparam logic [7:0] PAD_RSVD_0   = 8'hFF;
  localparam logic [7:0] PAD_RSVD_1   = 8'h00;
  localparam logic [7:0] PAD_RSVD_2   = 8'h10;

  // register reset values
  localparam logic [7:0] TH_DEFAULT  = 8'h4B;
  localparam logic [7:0] TL_DEFAULT  = 8'h46;
  localparam logic [7:0] CFG_DEFAULT = 8'h7F;

  // reflected form of x^8+x^5+x^4+1
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // bytes covered by the crc; the crc itself follows them on a read
  localparam int PAD_LEN = 8;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_WRITE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_OK      = 3'd1,
    KIND_UNKNOWN = 3'd2,
    KIND_MORE    = 3'd3,
    KIND_IGNORED = 3'd4,
    KIND_RESET   = 3'd5
  } kind_t;

  // one classified item, with a snapshot of the scratchpad for reads
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  th;
    logic [7:0]  tl;
    logic [7:0]  cfg;
    logic [7:0]  crc;
  } cmd_rec_t;

  // front to crc unit
  typedef struct packed {
    logic        start;
    logic [7:0]  th;
    logic [7:0]  tl;
    logic [7:0]  cfg;
  } crc_req_t;

  // crc unit to front
  typedef struct packed {
    logic        busy;
    logic [7:0]  value;
  } crc_status_t;

  function automatic logic [7:0] pad_byte(input logic [2:0] idx, input logic [7:0] th,
                                          input logic [7:0] tl, input logic [7:0] cfg);
    logic [7:0] b;
    case (idx)
      3'd0:    b = PAD_TEMP_LSB;
      3'd1:    b = PAD_TEMP_MSB;
      3'd2:    b = th;
      3'd3:    b = tl;
      3'd4:    b = cfg;
      3'd5:    b = PAD_RSVD_0;
      3'd6:    b = PAD_RSVD_1;
      default: b = PAD_RSVD_2;
    endcase
    return b;
  endfunction

  // eight bit steps of the crc over one byte, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] v_in);
    logic [7:0] c;
    logic [7:0] v;
    c = crc_in;
    v = v_in;
    for (int b = 0; b < 8; b++) begin
      if (c[0] ^ v[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    return c;
  endfunction

  // whole-pad crc, used only for the reset constant
  function automatic logic [7:0] crc8_pad(input logic [7:0] th, input logic [7:0] tl,
                                          input logic [7:0] cfg);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < PAD_LEN; i++) begin
      c = crc8_byte(c, pad_byte(3'(i), th, tl, cfg));
    end
    return c;
  endfunction

  localparam logic [7:0] CRC_DEFAULT = crc8_pad(TH_DEFAULT, TL_DEFAULT, CFG_DEFAULT);

endpackage

// File: rtl/sts_crc.sv
// byte-serial crc8 unit holding the stored scratchpad crc
module sts_crc
  import sts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  crc_req_t    req,
  output crc_status_t status
);

  logic       busy;
  logic [2:0] idx;
  logic [7:0] acc;
  logic [7:0] value;
  logic [7:0] acc_next;

  // one scratchpad byte per cycle from the live registers
  assign acc_next = crc8_byte(acc, pad_byte(idx, req.th, req.tl, req.cfg));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      value <= CRC_DEFAULT;
    end else if (req.start) begin
      busy <= 1'b1;
      acc  <= 8'h00;
      idx  <= 3'd0;
    end else if (busy) begin
      acc <= acc_next;
      idx <= idx + 3'd1;
      if (idx == 3'(PAD_LEN - 1)) begin
        value <= acc_next;
        busy  <= 1'b0;
      end
    end
  end

  assign status.busy  = busy;
  assign status.value = value;

  // a new pass never lands on one in flight
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("crc start while busy");

endmodule

// File: rtl/sts_fifo.sv
// short queue of classified items between front and back
module sts_fifo
  import sts_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  cmd_rec_t push_rec,
  input  logic     pop,
  output cmd_rec_t head,
  output logic     full,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_rec_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/sts_front.sv
// front: takes items, runs the command phase machine and the scratchpad registers
module sts_front
  import sts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  data_byte,
  output logic        push,
  output cmd_rec_t    rec,
  input  logic        full,
  output crc_req_t    crc_req,
  input  crc_status_t crc_st
);

  phase_t     phase, phase_next;
  logic [1:0] write_count, write_count_next;
  logic [7:0] alarm_high, alarm_low, config_byte;
  logic       accept;
  logic       wr_th, wr_tl, wr_cfg;

  // hold off while the crc is being rebuilt so reads see the new value
  assign in_ready = !full && !crc_st.busy;
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    phase_next       = phase;
    write_count_next = write_count;
    if (accept) begin
      if (func) begin
        phase_next       = PH_WAIT;
        write_count_next = 2'd0;
      end else begin
        case (phase)
          PH_WAIT: begin
            write_count_next = 2'd0;
            phase_next       = (data_byte == CMD_WRITE) ? PH_WRITE : PH_DONE;
          end
          PH_WRITE: begin
            if (write_count[1]) begin
              phase_next       = PH_DONE;
              write_count_next = 2'd0;
            end else begin
              write_count_next = write_count + 2'd1;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    push          = accept;
    rec.kind      = KIND_IGNORED;
    rec.th        = alarm_high;
    rec.tl        = alarm_low;
    rec.cfg       = config_byte;
    rec.crc       = crc_st.value;
    crc_req.start = 1'b0;
    crc_req.th    = alarm_high;
    crc_req.tl    = alarm_low;
    crc_req.cfg   = config_byte;
    wr_th         = 1'b0;
    wr_tl         = 1'b0;
    wr_cfg        = 1'b0;
    if (accept) begin
      if (func) begin
        rec.kind      = KIND_RESET;
        crc_req.start = (phase == PH_WRITE);
      end else begin
        case (phase)
          PH_WAIT: begin
            case (data_byte)
              CMD_WRITE:                         rec.kind = KIND_MORE;
              CMD_READ:                          rec.kind = KIND_READ;
              CMD_CONVERT, CMD_RECALL, CMD_POWER: rec.kind = KIND_OK;
              default:                           rec.kind = KIND_UNKNOWN;
            endcase
          end
          PH_WRITE: begin
            wr_th  = (write_count == 2'd0);
            wr_tl  = (write_count == 2'd1);
            wr_cfg = write_count[1];
            if (write_count[1]) begin
              rec.kind      = KIND_OK;
              crc_req.start = 1'b1;
            end else begin
              rec.kind = KIND_MORE;
            end
          end
          default: begin
            rec.kind = KIND_IGNORED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      write_count <= 2'd0;
      alarm_high  <= TH_DEFAULT;
      alarm_low   <= TL_DEFAULT;
      config_byte <= CFG_DEFAULT;
    end else begin
      phase       <= phase_next;
      write_count <= write_count_next;
      if (wr_th) begin
        alarm_high <= data_byte;
      end
      if (wr_tl) begin
        alarm_low <= data_byte;
      end
      if (wr_cfg) begin
        config_byte <= data_byte;
      end
    end
  end

  // a reset that cuts a write short must rebuild the crc
  a_cut_write_crc: assert property (@(posedge clk) disable iff (rst)
    (accept && func && phase == PH_WRITE) |=> crc_st.busy)
    else $error("crc not rebuilt after interrupted write");

endmodule

// File: rtl/sts_back.sv
// back: expands queued items into result items through an output register
module sts_back
  import sts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_rec_t    head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        last
);

  kind_t      kind;
  logic       busy;
  logic [3:0] cnt;
  cmd_rec_t   cur;
  logic       load;

  // output register is free when empty or being taken
  assign load = !out_valid || out_ready;
  assign pop  = load && !busy && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      cnt       <= 4'd0;
    end else if (load) begin
      if (busy) begin
        out_valid <= 1'b1;
        kind      <= KIND_READ;
        cnt       <= cnt + 4'd1;
        if (cnt == 4'(PAD_LEN)) begin
          out_byte <= cur.crc;
          last     <= 1'b1;
          busy     <= 1'b0;
        end else begin
          out_byte <= pad_byte(cnt[2:0], cur.th, cur.tl, cur.cfg);
          last     <= 1'b0;
        end
      end else if (!empty) begin
        out_valid <= 1'b1;
        kind      <= head.kind;
        if (head.kind == KIND_READ) begin
          out_byte <= pad_byte(3'd0, head.th, head.tl, head.cfg);
          last     <= 1'b0;
          busy     <= 1'b1;
          cnt      <= 4'd1;
          cur      <= head;
        end else begin
          out_byte <= 8'h00;
          last     <= 1'b1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_kind = 3'(kind);

  // only a read is ever expanded into several results
  a_expand_read: assert property (@(posedge clk) disable iff (rst)
    busy |-> cur.kind == KIND_READ)
    else $error("expanding a non-read item");
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_READ) |-> (last && out_byte == 8'h00))
    else $error("bad non-read result");

endmodule

// File: rtl/temp_sensor_scratchpad_slave.sv
// top level of the one-wire sensor scratchpad command handler
//
//   channel   signals                                   direction
//   input     in_valid, in_ready, func, data_byte       in  (ready out)
//   output    out_valid, out_ready, out_kind,           out (ready in)
//             out_byte, last
//
// each item gives one result, except a read scratchpad command which gives
// nine, one per cycle from the output register as the output port allows.
// completing a write, or a reset that cuts one short, starts the crc unit,
// which folds one scratchpad byte per cycle: no item is taken while it runs.
// rst is synchronous and returns the scratchpad to its default contents.
// the queue lets the front keep taking items while results wait downstream.
module temp_sensor_scratchpad_slave
  import sts_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       last
);

  // front to queue
  logic        push;
  cmd_rec_t    rec;
  // queue to back
  cmd_rec_t    head;
  logic        full;
  logic        empty;
  logic        pop;
  // crc unit link
  crc_req_t    crc_req;
  crc_status_t crc_st;

  // phase machine and scratchpad registers; classifies each item
  sts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_byte (data_byte),
    .push      (push),
    .rec       (rec),
    .full      (full),
    .crc_req   (crc_req),
    .crc_st    (crc_st)
  );

  // stored crc and its byte-serial rebuild
  sts_crc u_crc (
    .clk    (clk),
    .rst    (rst),
    .req    (crc_req),
    .status (crc_st)
  );

  // classified items with their scratchpad snapshot
  sts_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (rec),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  // result sequencing onto the output channel
  sts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

// File: bench/tb_temp_sensor_scratchpad_slave.sv
// testbench for the scratchpad command handler: predicted replies checked against the block
`timescale 1ns / 1ps

module tb_temp_sensor_scratchpad_slave;
  import sts_pkg::*;

  // run length bounds
  localparam int          ITEM_COUNT   = 430;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 40;

  // meaning of the func input
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_RESET = 1'b1;

  // one reply as it should leave the block
  typedef struct {
    kind_t      kind;
    logic [7:0] val;
    logic       is_last;
  } reply_t;

  // scratchpad behaviour model plus the queue of replies still owed by the block
  class pad_scoreboard;
    phase_t     phase;
    logic [1:0] wr_count;
    logic [7:0] th;
    logic [7:0] tl;
    logic [7:0] cfg;
    logic [7:0] crc;
    reply_t     pending_replies[$];
    int         failures;

    function new();
      phase        = PH_WAIT;
      wr_count     = 2'd0;
      th           = TH_DEFAULT;
      tl           = TL_DEFAULT;
      cfg          = CFG_DEFAULT;
      failures     = 0;
      crc          = pad_crc();
    endfunction

    // crc8 over the eight pad bytes, lsb first, reflected polynomial
    function logic [7:0] pad_crc();
      logic [7:0] pad [8];
      logic [7:0] acc;
      logic [7:0] v;
      logic       mix;
      pad = '{PAD_TEMP_LSB, PAD_TEMP_MSB, th, tl, cfg, PAD_RSVD_0, PAD_RSVD_1, PAD_RSVD_2};
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
        v = pad[i];
        for (int b = 0; b < 8; b++) begin
          mix = acc[0] ^ v[0];
          acc = acc >> 1;
          if (mix) begin
            acc = acc ^ CRC_POLY;
          end
          v = v >> 1;
        end
      end
      return acc;
    endfunction

    function void owe(kind_t kind, logic [7:0] val, logic is_last);
      reply_t r;
      r.kind    = kind;
      r.val     = val;
      r.is_last = is_last;
      pending_replies.push_back(r);
    endfunction

    // advance the model by one accepted item and queue what it must produce
    function void take_bus_item(logic is_reset, logic [7:0] d);
      logic [7:0] pad [8];
      if (is_reset) begin
        if (phase == PH_WRITE) begin
          crc = pad_crc();
        end
        phase    = PH_WAIT;
        wr_count = 2'd0;
        owe(KIND_RESET, 8'h00, 1'b1);
        return;
      end
      case (phase)
        PH_WAIT: begin
          if (d == CMD_WRITE) begin
            phase    = PH_WRITE;
            wr_count = 2'd0;
            owe(KIND_MORE, 8'h00, 1'b1);
          end else begin
            phase = PH_DONE;
            if (d == CMD_READ) begin
              pad = '{PAD_TEMP_LSB, PAD_TEMP_MSB, th, tl, cfg,
                      PAD_RSVD_0, PAD_RSVD_1, PAD_RSVD_2};
              for (int i = 0; i < 8; i++) begin
                owe(KIND_READ, pad[i], 1'b0);
              end
              owe(KIND_READ, crc, 1'b1);
            end else if (d == CMD_RECALL || d == CMD_POWER || d == CMD_CONVERT) begin
              owe(KIND_OK, 8'h00, 1'b1);
            end else begin
              owe(KIND_UNKNOWN, 8'h00, 1'b1);
            end
          end
        end
        PH_WRITE: begin
          case (wr_count)
            2'd0:    th  = d;
            2'd1:    tl  = d;
            default: cfg = d;
          endcase
          wr_count = wr_count + 2'd1;
          if (wr_count == 2'd3) begin
            crc      = pad_crc();
            phase    = PH_DONE;
            wr_count = 2'd0;
            owe(KIND_OK, 8'h00, 1'b1);
          end else begin
            owe(KIND_MORE, 8'h00, 1'b1);
          end
        end
        default: owe(KIND_IGNORED, 8'h00, 1'b1);
      endcase
    endfunction

    // compare one reply from the block with the oldest one owed
    function void check_reply(logic [2:0] kind, logic [7:0] val, logic is_last);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: out_kind %0d out_byte %h last %b", kind, val, is_last);
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      if (kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, kind);
        failures++;
      end
      if (val !== want.val) begin
        $error("out_byte: expected %h, got %h", want.val, val);
        failures++;
      end
      if (is_last !== want.is_last) begin
        $error("last: expected %b, got %b", want.is_last, is_last);
        failures++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic       func      = FUNC_BYTE;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       last;

  pad_scoreboard sb;
  int unsigned   cycle_count = 0;
  int            items_sent  = 0;
  // when set, neither side idles: back-to-back items and a ready that never drops
  bit            steady = 1'b0;

  temp_sensor_scratchpad_slave uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .last      (last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // present one item, after an optional idle stretch, and hold it until taken
  task automatic send_item(input logic is_reset, input logic [7:0] value);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= is_reset;
    data_byte <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // both handshakes observed on the same edge; the item goes in first so that
  // its replies are already queued should the block answer without delay
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.take_bus_item(func, data_byte);
      end
      if (out_valid && out_ready) begin
        sb.check_reply(out_kind, out_byte, last);
      end
    end
  end

  // receiver: ready runs broken by stalls of random length
  initial begin
    int run_len;
    int stall_len;
    @(posedge clk);
    forever begin
      run_len = steady ? 20 : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = steady ? 0 : pick_gap();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int   r;
    int   n;
    logic [7:0] cmd;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: read of the default pad straight out of reset
    send_item(FUNC_BYTE, CMD_READ);
    send_item(FUNC_BYTE, 8'h00);        // ignored once the read is done
    send_item(FUNC_RESET, 8'h00);
    // full write with extreme values, then a stray byte
    send_item(FUNC_BYTE, CMD_WRITE);
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'h80);
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_RESET, 8'hFF);       // data ignored on a bus reset
    send_item(FUNC_BYTE, CMD_READ);
    send_item(FUNC_RESET, 8'h00);
    // write cut short by a reset: crc refreshed, first byte kept
    send_item(FUNC_BYTE, CMD_WRITE);
    send_item(FUNC_BYTE, 8'h12);
    send_item(FUNC_RESET, 8'h00);
    send_item(FUNC_RESET, 8'h55);       // reset while already waiting
    send_item(FUNC_BYTE, CMD_READ);
    // no-op commands
    send_item(FUNC_RESET, 8'h00);
    send_item(FUNC_BYTE, CMD_CONVERT);
    send_item(FUNC_RESET, 8'h00);
    send_item(FUNC_BYTE, CMD_RECALL);
    send_item(FUNC_RESET, 8'h00);
    send_item(FUNC_BYTE, CMD_POWER);
    // rejected command, then bytes ignored until the next reset
    send_item(FUNC_RESET, 8'h00);
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_BYTE, 8'h01);
    send_item(FUNC_RESET, 8'h00);

    // random: mostly whole transactions with random content, some noise
    while (items_sent < ITEM_COUNT) begin
      steady = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_item(FUNC_RESET, 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 35) begin
          send_item(FUNC_BYTE, CMD_WRITE);
          // a short write is left for the next reset to cut
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 3;
          repeat (n) send_item(FUNC_BYTE, 8'($urandom));
        end else if (r < 65) begin
          send_item(FUNC_BYTE, CMD_READ);
        end else if (r < 82) begin
          case ($urandom_range(0, 2))
            0:       cmd = CMD_CONVERT;
            1:       cmd = CMD_RECALL;
            default: cmd = CMD_POWER;
          endcase
          send_item(FUNC_BYTE, cmd);
        end else begin
          send_item(FUNC_BYTE, 8'($urandom));
        end
        // trailing bytes after completion
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) send_item(FUNC_BYTE, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(($urandom_range(0, 3) == 0) ? FUNC_RESET : FUNC_BYTE, 8'($urandom));
        end
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain, then allow the crc unit time to settle
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sts_pkg.sv
rtl/sts_crc.sv
rtl/sts_fifo.sv
rtl/sts_front.sv
rtl/sts_back.sv
rtl/temp_sensor_scratchpad_slave.sv
bench/tb_temp_sensor_scratchpad_slave.sv
